/* sv/template_match_counter_2d_unit_defines.svh */
// Assertion macros for the template match counter.
// Included by the top level; compiled out when SYNTH is defined.
`ifndef TEMPLATE_MATCH_COUNTER_2D_UNIT_DEFINES_SVH
`define TEMPLATE_MATCH_COUNTER_2D_UNIT_DEFINES_SVH

`ifndef SYNTH
`define TMC2D_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define TMC2D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define TMC2D_ASSERT_SAME(lbl, ante, cons)
`define TMC2D_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/tmc2d_pkg.sv */
// Shared constants and types for the template match counter.
// No dependencies.
`timescale 1ns / 1ps

package tmc2d_pkg;

    localparam int MAX_IMAGE_ROWS    = 64;
    localparam int MAX_IMAGE_COLS    = 64;
    localparam int MAX_TEMPLATE_ROWS = 16;
    localparam int MAX_TEMPLATE_COLS = 16;

    localparam int IMG_ROW_W = $clog2(MAX_IMAGE_ROWS);
    localparam int IMG_COL_W = $clog2(MAX_IMAGE_COLS);
    localparam int TPL_ROW_W = $clog2(MAX_TEMPLATE_ROWS);
    localparam int TPL_COL_W = $clog2(MAX_TEMPLATE_COLS);
    localparam int IMG_SZ_W  = 7;
    localparam int TPL_SZ_W  = 5;
    localparam int IMG_AW    = IMG_ROW_W + IMG_COL_W;
    localparam int TPL_AW    = TPL_ROW_W + TPL_COL_W;

    localparam int MODE_W   = 2;
    localparam int COORD_W  = 6;
    localparam int PIXEL_W  = 8;
    localparam int COUNT_W  = 13;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_TPL   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_IMG   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;

    localparam logic [CFG_AW-1:0] REG_IMAGE_ROWS    = 2'd0;
    localparam logic [CFG_AW-1:0] REG_IMAGE_COLS    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_TEMPLATE_ROWS = 2'd2;
    localparam logic [CFG_AW-1:0] REG_TEMPLATE_COLS = 2'd3;

    typedef struct packed {
        logic wr_en;
        logic start;
        logic zero;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic fits;
        logic scan_end;
        logic out_busy;
    } status_t;

endpackage

/* sv/tmc2d_ctrl.sv */
// Controller FSM: accepts items, sequences the read/compare scan.
// Depends on tmc2d_pkg.
`timescale 1ns / 1ps

module tmc2d_ctrl
    import tmc2d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [MODE_W-1:0] in_mode,
    output logic              in_ready,
    input  status_t           status,
    output cmd_t              cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE) && !(status.out_busy && in_mode == MODE_COUNT);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_en = accept && (in_mode == MODE_TPL || in_mode == MODE_IMG);
                if (accept && in_mode == MODE_COUNT)
                begin
                    if (status.fits)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        cmd.zero = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.step   = 1'b1;
                state_next = status.scan_end ? ST_IDLE : ST_READ;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/tmc2d_datapath.sv */
// Datapath: size registers, image/template memories, scan counters,
// match counter and output register. Depends on tmc2d_pkg.
`timescale 1ns / 1ps

module tmc2d_datapath
    import tmc2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [CFG_DW-1:0]  cfg_wdata,
    input  logic [MODE_W-1:0]  in_mode,
    input  logic [COORD_W-1:0] in_row,
    input  logic [COORD_W-1:0] in_col,
    input  logic [PIXEL_W-1:0] in_pixel,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [COUNT_W-1:0] match_count
);

    logic [IMG_SZ_W-1:0]  ir_reg, ic_reg;
    logic [TPL_SZ_W-1:0]  tr_reg, tc_reg;
    logic [IMG_SZ_W-1:0]  ir_eff, ic_eff;
    logic [TPL_SZ_W-1:0]  tr_eff, tc_eff;

    logic [PIXEL_W-1:0]   img_mem [2**IMG_AW];
    logic [PIXEL_W-1:0]   tpl_mem [2**TPL_AW];
    logic [PIXEL_W-1:0]   img_q, tpl_q;
    logic [IMG_AW-1:0]    img_raddr;
    logic [TPL_AW-1:0]    tpl_raddr;
    logic                 img_we, tpl_we;

    logic [IMG_ROW_W-1:0] i_reg, i_next;
    logic [IMG_COL_W-1:0] j_reg, j_next;
    logic [TPL_ROW_W-1:0] k_reg, k_next;
    logic [TPL_COL_W-1:0] l_reg, l_next;
    logic [COUNT_W-1:0]   n_reg, n_next;
    logic                 out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic match, last_k, last_l, last_i, last_j, last_kl, pos_end, last_pos, hit;

    // effective sizes: zero reads as one, large values clamp to the maximum
    always_comb
    begin
        ir_eff = (ir_reg == '0) ? IMG_SZ_W'(1)
               : (ir_reg > IMG_SZ_W'(MAX_IMAGE_ROWS)) ? IMG_SZ_W'(MAX_IMAGE_ROWS) : ir_reg;
        ic_eff = (ic_reg == '0) ? IMG_SZ_W'(1)
               : (ic_reg > IMG_SZ_W'(MAX_IMAGE_COLS)) ? IMG_SZ_W'(MAX_IMAGE_COLS) : ic_reg;
        tr_eff = (tr_reg == '0) ? TPL_SZ_W'(1)
               : (tr_reg > TPL_SZ_W'(MAX_TEMPLATE_ROWS)) ? TPL_SZ_W'(MAX_TEMPLATE_ROWS) : tr_reg;
        tc_eff = (tc_reg == '0) ? TPL_SZ_W'(1)
               : (tc_reg > TPL_SZ_W'(MAX_TEMPLATE_COLS)) ? TPL_SZ_W'(MAX_TEMPLATE_COLS) : tc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_reg <= IMG_SZ_W'(MAX_IMAGE_ROWS);
            ic_reg <= IMG_SZ_W'(MAX_IMAGE_COLS);
            tr_reg <= TPL_SZ_W'(MAX_TEMPLATE_ROWS);
            tc_reg <= TPL_SZ_W'(MAX_TEMPLATE_COLS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_IMAGE_ROWS:    ir_reg <= cfg_wdata;
                REG_IMAGE_COLS:    ic_reg <= cfg_wdata;
                REG_TEMPLATE_ROWS: tr_reg <= cfg_wdata[TPL_SZ_W-1:0];
                REG_TEMPLATE_COLS: tc_reg <= cfg_wdata[TPL_SZ_W-1:0];
                default: ;
            endcase
        end
    end

    // load writes, dropped outside the sizes in use
    assign tpl_we = cmd.wr_en && in_mode == MODE_TPL
                 && {1'b0, in_row} < IMG_SZ_W'(tr_eff)
                 && {1'b0, in_col} < IMG_SZ_W'(tc_eff);
    assign img_we = cmd.wr_en && in_mode == MODE_IMG
                 && {1'b0, in_row} < ir_eff
                 && {1'b0, in_col} < ic_eff;

    assign img_raddr = {IMG_ROW_W'(i_reg + IMG_ROW_W'(k_reg)),
                        IMG_COL_W'(j_reg + IMG_COL_W'(l_reg))};
    assign tpl_raddr = {k_reg, l_reg};

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            img_mem[{in_row[IMG_ROW_W-1:0], in_col[IMG_COL_W-1:0]}] <= in_pixel;
        end
        img_q <= img_mem[img_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tpl_we)
        begin
            tpl_mem[{in_row[TPL_ROW_W-1:0], in_col[TPL_COL_W-1:0]}] <= in_pixel;
        end
        tpl_q <= tpl_mem[tpl_raddr];
    end

    // scan: positions (i, j), template offsets (k, l); a mismatch ends a position early
    assign match    = (img_q == tpl_q);
    assign last_k   = (k_reg == TPL_ROW_W'(tr_eff - TPL_SZ_W'(1)));
    assign last_l   = (l_reg == TPL_COL_W'(tc_eff - TPL_SZ_W'(1)));
    assign last_i   = (i_reg == IMG_ROW_W'(ir_eff - IMG_SZ_W'(tr_eff)));
    assign last_j   = (j_reg == IMG_COL_W'(ic_eff - IMG_SZ_W'(tc_eff)));
    assign last_kl  = last_k && last_l;
    assign pos_end  = !match || last_kl;
    assign last_pos = last_i && last_j;
    assign hit      = match && last_kl && (n_reg != COUNT_MAX);

    assign status.fits     = (ir_eff >= IMG_SZ_W'(tr_eff)) && (ic_eff >= IMG_SZ_W'(tc_eff));
    assign status.scan_end = pos_end && last_pos;
    assign status.out_busy = out_valid_reg;

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        l_next = l_reg;
        n_next = n_reg;
        if (cmd.start)
        begin
            i_next = '0;
            j_next = '0;
            k_next = '0;
            l_next = '0;
            n_next = '0;
        end
        else if (cmd.step)
        begin
            if (pos_end)
            begin
                k_next = '0;
                l_next = '0;
                if (hit)
                begin
                    n_next = n_reg + COUNT_W'(1);
                end
                if (last_j)
                begin
                    j_next = '0;
                    i_next = i_reg + IMG_ROW_W'(1);
                end
                else
                begin
                    j_next = j_reg + IMG_COL_W'(1);
                end
            end
            else if (last_l)
            begin
                l_next = '0;
                k_next = k_reg + TPL_ROW_W'(1);
            end
            else
            begin
                l_next = l_reg + TPL_COL_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        if (cmd.zero)
        begin
            out_valid_next = 1'b1;
            count_next     = '0;
        end
        else if (cmd.step && status.scan_end)
        begin
            out_valid_next = 1'b1;
            count_next     = n_next;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        l_reg     <= l_next;
        n_reg     <= n_next;
        count_reg <= count_next;
    end

    assign out_valid   = out_valid_reg;
    assign match_count = count_reg;

endmodule

/* sv/template_match_counter_2d_unit.sv */
// Load items (template/image byte writes) are accepted back to back.
// Count item: accepted, then a memory read state and a compare state per byte
// compared; a position stops at its first mismatch. Result is registered.
// Count with template larger than image: result the cycle after accept.
// Reset: sizes 64/64/16/16, no result pending; memory contents undefined.
`timescale 1ns / 1ps
`include "template_match_counter_2d_unit_defines.svh"

module template_match_counter_2d_unit
    import tmc2d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // mode[1:0], row[7:2], col[13:8], pixel[21:14]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata    // match_count[12:0]
);

    cmd_t               cmd;
    status_t            status;
    logic [COUNT_W-1:0] match_count;

    tmc2d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_mode  (s_tdata[1:0]),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tmc2d_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_mode     (s_tdata[1:0]),
        .in_row      (s_tdata[7:2]),
        .in_col      (s_tdata[13:8]),
        .in_pixel    (s_tdata[21:14]),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .match_count (match_count)
    );

    assign m_tdata = {3'b000, match_count};

    `TMC2D_ASSERT_SAME(a_count_needs_free_out, s_tvalid && s_tready && s_tdata[1:0] == MODE_COUNT, !m_tvalid)
    `TMC2D_ASSERT_NEXT(a_scan_end_gives_result, cmd.step && status.scan_end, m_tvalid)
    `TMC2D_ASSERT_NEXT(a_no_fit_gives_zero, cmd.zero, m_tvalid && m_tdata[12:0] == '0)
    `TMC2D_ASSERT_SAME(a_no_accept_while_scanning, cmd.step, !s_tready)

endmodule

/* test/tb.sv */
// Self-checking bench for template_match_counter_2d_unit: loads template and image
// bytes, runs match counts, checks each count against a shadow copy of both stores.
// Depends on tmc2d_pkg and the unit itself.
`timescale 1ns / 1ps

module tb;
    import tmc2d_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 500;

    typedef enum int {PACE_FREE, PACE_TX_IDLE, PACE_RX_STALL, PACE_BOTH} pace_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [MODE_W-1:0]  mode;
    } load_item_t;

    class match_count_board;
        logic [PIXEL_W-1:0] img [MAX_IMAGE_ROWS*MAX_IMAGE_COLS];
        logic [PIXEL_W-1:0] tpl [MAX_TEMPLATE_ROWS*MAX_TEMPLATE_COLS];
        logic [CFG_DW-1:0]  sizes [4];
        logic [COUNT_W-1:0] pending_counts [$];
        int failures;

        function new();
            foreach (img[i]) img[i] = '0;
            foreach (tpl[i]) tpl[i] = '0;
            sizes[REG_IMAGE_ROWS]    = 7'd64;
            sizes[REG_IMAGE_COLS]    = 7'd64;
            sizes[REG_TEMPLATE_ROWS] = 7'd16;
            sizes[REG_TEMPLATE_COLS] = 7'd16;
            failures = 0;
        endfunction

        function void set_size(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
            if (idx == REG_IMAGE_ROWS || idx == REG_IMAGE_COLS)
                sizes[idx] = val;
            else
                sizes[idx] = {2'b00, val[TPL_SZ_W-1:0]};
        endfunction

        // effective size: zero reads as 1, oversize clamps to the maximum
        function int span(logic [CFG_AW-1:0] idx);
            int lim;
            int raw;
            raw = sizes[idx];
            case (idx)
                REG_IMAGE_ROWS:    lim = MAX_IMAGE_ROWS;
                REG_IMAGE_COLS:    lim = MAX_IMAGE_COLS;
                REG_TEMPLATE_ROWS: lim = MAX_TEMPLATE_ROWS;
                default:           lim = MAX_TEMPLATE_COLS;
            endcase
            if (raw == 0)
                return 1;
            return (raw > lim) ? lim : raw;
        endfunction

        function logic [COUNT_W-1:0] tally_matches();
            int ir, ic, tr, tc, n, i, j, k, l;
            bit hit;
            ir = span(REG_IMAGE_ROWS);
            ic = span(REG_IMAGE_COLS);
            tr = span(REG_TEMPLATE_ROWS);
            tc = span(REG_TEMPLATE_COLS);
            n = 0;
            if (tr > ir || tc > ic)
                return '0;
            for (i = 0; i + tr <= ir; i++)
            begin
                for (j = 0; j + tc <= ic; j++)
                begin
                    hit = 1'b1;
                    for (k = 0; hit && k < tr; k++)
                        for (l = 0; hit && l < tc; l++)
                            if (img[(i + k) * MAX_IMAGE_COLS + j + l] !=
                                tpl[k * MAX_TEMPLATE_COLS + l])
                                hit = 1'b0;
                    if (hit && n < COUNT_MAX)
                        n++;
                end
            end
            return n[COUNT_W-1:0];
        endfunction

        // returns 1 when the item stored a byte or asked for a count
        function bit take_item(load_item_t it);
            case (it.mode)
                MODE_TPL:
                begin
                    if (it.row < span(REG_TEMPLATE_ROWS) && it.col < span(REG_TEMPLATE_COLS))
                    begin
                        tpl[it.row * MAX_TEMPLATE_COLS + it.col] = it.pixel;
                        return 1'b1;
                    end
                end
                MODE_IMG:
                begin
                    if (it.row < span(REG_IMAGE_ROWS) && it.col < span(REG_IMAGE_COLS))
                    begin
                        img[it.row * MAX_IMAGE_COLS + it.col] = it.pixel;
                        return 1'b1;
                    end
                end
                MODE_COUNT:
                begin
                    pending_counts.push_back(tally_matches());
                    return 1'b1;
                end
                default: ;
            endcase
            return 1'b0;
        endfunction

        function void flag(string what, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
            failures++;
            if (failures <= 10)
                $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
        endfunction

        function void check_count(logic [COUNT_W-1:0] got);
            logic [COUNT_W-1:0] want;
            if (pending_counts.size() == 0)
            begin
                flag("match_count with none pending", 'x, got);
                return;
            end
            want = pending_counts.pop_front();
            if (want !== got)
                flag("match_count mismatch", want, got);
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;

    match_count_board board;

    bit img_seen [MAX_IMAGE_ROWS*MAX_IMAGE_COLS];
    bit tpl_seen [MAX_TEMPLATE_ROWS*MAX_TEMPLATE_COLS];
    int fed_items    = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;

    template_match_counter_2d_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                board.check_count(m_tdata[COUNT_W-1:0]);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic int pick_pixel();
        int p;
        p = $urandom_range(99);
        if (p < 75)
            return $urandom_range(1);
        if (p < 85)
            return $urandom_range(1) ? 255 : 0;
        return $urandom_range(255);
    endfunction

    task automatic set_pace(pace_t p);
        case (p)
            PACE_FREE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            PACE_TX_IDLE:  begin tx_idle_pct = 86; rx_stall_pct = 0;  end
            PACE_RX_STALL: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
            default:       begin tx_idle_pct = 34; rx_stall_pct = 34; end
        endcase
    endtask

    task automatic put_item(logic [MODE_W-1:0] mode, int row, int col, int pix);
        load_item_t it;
        it.mode  = mode;
        it.row   = COORD_W'(row);
        it.col   = COORD_W'(col);
        it.pixel = PIXEL_W'(pix);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it};
        do
            @(posedge clk);
        while (!s_tready);
        if (board.take_item(it))
        begin
            if (mode == MODE_TPL)
                tpl_seen[it.row * MAX_TEMPLATE_COLS + it.col] = 1'b1;
            else if (mode == MODE_IMG)
                img_seen[it.row * MAX_IMAGE_COLS + it.col] = 1'b1;
            fed_items++;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending_counts.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sizes(int ir, int ic, int tr, int tc);
        logic [CFG_DW-1:0] v [4];
        int i;
        v[REG_IMAGE_ROWS]    = CFG_DW'(ir);
        v[REG_IMAGE_COLS]    = CFG_DW'(ic);
        v[REG_TEMPLATE_ROWS] = CFG_DW'(tr);
        v[REG_TEMPLATE_COLS] = CFG_DW'(tc);
        for (i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_AW'(i);
            cfg_wdata <= v[i];
            board.set_size(CFG_AW'(i), v[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // every entry a count may read gets written first
    task automatic fill_regions();
        int r, c;
        for (r = 0; r < board.span(REG_TEMPLATE_ROWS); r++)
            for (c = 0; c < board.span(REG_TEMPLATE_COLS); c++)
                if (!tpl_seen[r * MAX_TEMPLATE_COLS + c])
                    put_item(MODE_TPL, r, c, pick_pixel());
        for (r = 0; r < board.span(REG_IMAGE_ROWS); r++)
            for (c = 0; c < board.span(REG_IMAGE_COLS); c++)
                if (!img_seen[r * MAX_IMAGE_COLS + c])
                    put_item(MODE_IMG, r, c, pick_pixel());
    endtask

    // copy the template into the image, optionally spoiling one byte
    task automatic plant(bit broken);
        int tr, tc, r0, c0, k, l;
        tr = board.span(REG_TEMPLATE_ROWS);
        tc = board.span(REG_TEMPLATE_COLS);
        r0 = $urandom_range(board.span(REG_IMAGE_ROWS) - tr);
        c0 = $urandom_range(board.span(REG_IMAGE_COLS) - tc);
        for (k = 0; k < tr; k++)
            for (l = 0; l < tc; l++)
                put_item(MODE_IMG, r0 + k, c0 + l, board.tpl[k * MAX_TEMPLATE_COLS + l]);
        if (broken)
        begin
            k = $urandom_range(tr - 1);
            l = $urandom_range(tc - 1);
            put_item(MODE_IMG, r0 + k, c0 + l, board.tpl[k * MAX_TEMPLATE_COLS + l] ^ 8'h01);
        end
    endtask

    task automatic run_phase(int pno);
        int ir, ic, tr, tc, n, len, pick;
        settle();
        case (pno)
            0:       write_sizes(64, 1, 16, 1);
            1:       write_sizes(1, 127, 7'h40, 7'h7F);
            2:       write_sizes(0, 0, 0, 0);
            3:       write_sizes(100, 1, 7'h30, 7'h21);
            default:
            begin
                ir = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
                ic = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
                tr = ($urandom_range(9) == 0) ? 0 :
                     ($urandom_range(19) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 3);
                tc = ($urandom_range(9) == 0) ? 0 :
                     ($urandom_range(19) == 0) ? $urandom_range(17, 31) : $urandom_range(1, 3);
                write_sizes(ir, ic, tr, tc);
            end
        endcase
        set_pace(pace_t'(pno % 4));
        fill_regions();
        if (pno == 2)
            hold_req++;
        ir = board.span(REG_IMAGE_ROWS);
        ic = board.span(REG_IMAGE_COLS);
        tr = board.span(REG_TEMPLATE_ROWS);
        tc = board.span(REG_TEMPLATE_COLS);
        len = $urandom_range(50, 90);
        for (n = 0; n < len; n++)
        begin
            if (n == len / 2 && pno % 3 == 1)
                drain();
            pick = $urandom_range(99);
            if (pick < 40)
                put_item(MODE_IMG, $urandom_range(ir - 1), $urandom_range(ic - 1), pick_pixel());
            else if (pick < 55)
                put_item(MODE_TPL, $urandom_range(tr - 1), $urandom_range(tc - 1), pick_pixel());
            else if (pick < 63)
                put_item($urandom_range(1) ? MODE_IMG : MODE_TPL,
                         $urandom_range(63), $urandom_range(63), pick_pixel());
            else if (pick < 74)
                put_item(MODE_COUNT, $urandom_range(63), $urandom_range(63),
                         $urandom_range(255));
            else if (pick < 78)
                put_item(MODE_NONE, $urandom_range(63), $urandom_range(63),
                         $urandom_range(255));
            else if (tr <= ir && tc <= ic)
                plant(pick >= 92);
        end
    endtask

    initial
    begin
        int pno;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // template taller than image: count is zero, nothing read
        set_pace(PACE_FREE);
        write_sizes(1, 64, 16, 16);
        put_item(MODE_COUNT, 63, 63, 255);
        put_item(MODE_TPL, 63, 63, 255);
        put_item(MODE_IMG, 1, 0, 0);
        put_item(MODE_NONE, 63, 63, 255);
        put_item(MODE_COUNT, 0, 0, 0);
        settle();

        // 2x3 image, 1x2 template: two hits, then one
        write_sizes(2, 3, 1, 2);
        put_item(MODE_TPL, 0, 0, 0);
        put_item(MODE_TPL, 0, 1, 255);
        put_item(MODE_IMG, 0, 0, 0);
        put_item(MODE_IMG, 0, 1, 255);
        put_item(MODE_IMG, 0, 2, 0);
        put_item(MODE_IMG, 1, 0, 255);
        put_item(MODE_IMG, 1, 1, 0);
        put_item(MODE_IMG, 1, 2, 255);
        put_item(MODE_COUNT, 0, 0, 0);
        put_item(MODE_IMG, 1, 2, 254);
        put_item(MODE_COUNT, 63, 63, 255);
        put_item(MODE_IMG, 2, 0, 7);
        put_item(MODE_TPL, 0, 2, 7);
        put_item(MODE_NONE, 0, 0, 0);
        put_item(MODE_COUNT, 21, 42, 170);

        pno = 0;
        while (fed_items < 1350)
        begin
            run_phase(pno);
            pno++;
        end
        settle();
        if (board.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #16_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
